[rtl/fsp_pkg.sv]
// Shared types, opcodes and field helpers for the five-stage pipelined core.
package fsp_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int NUM_REGS  = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [31:0]       word_t;
  typedef logic [2:0]        reg_idx_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  localparam word_t NOOP_WORD = {7'd0, OP_NOOP, 22'd0};

  typedef struct packed {
    word_t ins;
    addr_t next;
  } fd_t;

  typedef struct packed {
    word_t ins;
    addr_t next;
    word_t a;
    word_t b;
    word_t off;
  } de_t;

  typedef struct packed {
    word_t ins;
    addr_t target;
    logic  eq;
    word_t alu;
    word_t b;
  } em_t;

  typedef struct packed {
    word_t ins;
    word_t val;
  } wb_t;

  function automatic opcode_t opc(input word_t w);
    return opcode_t'(w[24:22]);
  endfunction

  function automatic reg_idx_t fa(input word_t w);
    return w[21:19];
  endfunction

  function automatic reg_idx_t fb(input word_t w);
    return w[18:16];
  endfunction

  function automatic word_t sext16(input word_t w);
    return {{16{w[15]}}, w[15:0]};
  endfunction

  function automatic logic writes_reg(input word_t w);
    return (opc(w) == OP_ADD) || (opc(w) == OP_NOR) || (opc(w) == OP_LW);
  endfunction

  function automatic reg_idx_t dest(input word_t w);
    return (opc(w) == OP_LW) ? fb(w) : w[2:0];
  endfunction

endpackage

[rtl/fsp_ram.sv]
// Generic single-write, single-read RAM with registered read (read-first).
module fsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    rd_addr;

  assign rd_addr = raddr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

endmodule

[rtl/five_stage_pipelined_cpu_core.sv]
// Top level of the five-stage pipelined core: pipeline latches, hazards, stores.
// The result of an item is registered at its accept edge.
// Throughput: one item per cycle while the result side takes results; the
//   single pass of stage logic (forwarding mux and one 32-bit ALU add feeding
//   the data store read address) sets the cycle time.
// Store reads are issued with the address that the state will hold after the edge.
// Reset (rst, synchronous): pipeline latches to noop, pc and cycle count to
//   zero, register file reads as zero; the two word stores are not cleared.
module five_stage_pipelined_cpu_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // address[9:0], data[41:10], zero pad
  input  logic [0:0]   s_tuser,   // action[0]: 0 load word, 1 step the pipeline
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // pc[9:0], cycle_count[41:10], halted[42],
                                  // reg_write_valid[43], reg_write_index[46:44],
                                  // reg_write_value[78:47], mem_write_valid[79],
                                  // mem_write_address[89:80],
                                  // mem_write_value[121:90], zero pad
);

  // Architectural state and pipeline latches
  fsp_pkg::addr_t pc, pc_next;
  fsp_pkg::word_t cycles, cycles_next;
  fsp_pkg::fd_t   fd, fd_next;
  fsp_pkg::de_t   de, de_next;
  fsp_pkg::em_t   em, em_next;
  fsp_pkg::wb_t   mw, mw_next;
  fsp_pkg::wb_t   wbe, wbe_next;

  logic           accept, act, run, stall, taken;
  fsp_pkg::addr_t ld_addr;
  fsp_pkg::word_t ld_data;

  // Store ports and read bypass
  logic           im_we, im_hit;
  fsp_pkg::addr_t im_raddr;
  fsp_pkg::word_t im_q, im_byp, ins_word;
  logic           dm_we, dm_hit, st_we;
  fsp_pkg::addr_t dm_waddr, dm_raddr;
  fsp_pkg::word_t dm_wdata, dm_q, dm_byp, dm_word;

  // Register file: two read copies, valid bits stand in for the zero reset
  logic                         rf_we;
  fsp_pkg::reg_idx_t            rf_waddr, ra, rb;
  fsp_pkg::word_t               rf_wdata, rfa_q, rfb_q, rfa_byp, rfb_byp, rf_a, rf_b;
  logic [fsp_pkg::NUM_REGS-1:0] rf_valid;
  logic                         rfa_hit, rfb_hit, rfa_ok, rfb_ok;

  // Execute stage
  fsp_pkg::word_t a_fw, b_fw, alu;

  // Result fields
  logic            halted_next;
  logic [127:0]    result;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign act      = s_tuser[0];
  assign ld_addr  = fsp_pkg::addr_t'(s_tdata[9:0]);
  assign ld_data  = s_tdata[41:10];
  assign run      = act && (fsp_pkg::opc(mw.ins) != fsp_pkg::OP_HALT);

  // Load-use hazard against the lw sitting in decode/execute
  assign stall = (fsp_pkg::opc(de.ins) == fsp_pkg::OP_LW) &&
                 ((fsp_pkg::fb(de.ins) == fsp_pkg::fb(fd.ins)) ||
                  (fsp_pkg::fb(de.ins) == fsp_pkg::fa(fd.ins)));

  assign taken = (fsp_pkg::opc(em.ins) == fsp_pkg::OP_BEQ) && em.eq;

  // Fold in a write that landed on the same edge as the read
  assign ins_word = im_hit ? im_byp : im_q;
  assign dm_word  = dm_hit ? dm_byp : dm_q;
  assign rf_a     = rfa_hit ? rfa_byp : (rfa_ok ? rfa_q : '0);
  assign rf_b     = rfb_hit ? rfb_byp : (rfb_ok ? rfb_q : '0);

  // Forwarding: nearest stage wins, so apply it last
  always_comb begin
    a_fw = de.a;
    b_fw = de.b;
    if (fsp_pkg::writes_reg(wbe.ins)) begin
      if (fsp_pkg::fa(de.ins) == fsp_pkg::dest(wbe.ins)) a_fw = wbe.val;
      if (fsp_pkg::fb(de.ins) == fsp_pkg::dest(wbe.ins)) b_fw = wbe.val;
    end
    if (fsp_pkg::writes_reg(mw.ins)) begin
      if (fsp_pkg::fa(de.ins) == fsp_pkg::dest(mw.ins)) a_fw = mw.val;
      if (fsp_pkg::fb(de.ins) == fsp_pkg::dest(mw.ins)) b_fw = mw.val;
    end
    if (fsp_pkg::writes_reg(em.ins)) begin
      if (fsp_pkg::fa(de.ins) == fsp_pkg::dest(em.ins)) a_fw = em.alu;
      if (fsp_pkg::fb(de.ins) == fsp_pkg::dest(em.ins)) b_fw = em.alu;
    end
  end

  always_comb begin
    unique case (fsp_pkg::opc(de.ins)) inside
      fsp_pkg::OP_ADD:                 alu = a_fw + b_fw;
      fsp_pkg::OP_NOR:                 alu = ~(a_fw | b_fw);
      fsp_pkg::OP_LW, fsp_pkg::OP_SW:  alu = a_fw + de.off;
      fsp_pkg::OP_BEQ:                 alu = a_fw - b_fw;
      default:                         alu = '0;
    endcase
  end

  // Pipeline step; every _next equals the current value unless a step runs
  always_comb begin
    pc_next     = pc;
    cycles_next = cycles;
    fd_next     = fd;
    de_next     = de;
    em_next     = em;
    mw_next     = mw;
    wbe_next    = wbe;
    im_we       = 1'b0;
    dm_we       = 1'b0;
    st_we       = 1'b0;
    dm_waddr    = ld_addr;
    dm_wdata    = ld_data;
    rf_we       = 1'b0;
    rf_waddr    = '0;
    rf_wdata    = '0;

    if (accept && !act) begin
      // load: same word into both stores
      im_we = 1'b1;
      dm_we = 1'b1;
    end else if (accept && run) begin
      cycles_next = cycles + 32'd1;

      // fetch
      fd_next.ins  = ins_word;
      fd_next.next = pc + fsp_pkg::addr_t'(1);
      pc_next      = fd_next.next;

      // decode; on a load-use hazard hold fetch and insert a bubble
      de_next.ins  = fd.ins;
      de_next.next = fd.next;
      if (stall) begin
        pc_next     = pc;
        fd_next     = fd;
        de_next.ins = fsp_pkg::NOOP_WORD;
      end else begin
        de_next.a   = rf_a;
        de_next.b   = rf_b;
        de_next.off = fsp_pkg::sext16(fd.ins);
      end

      // execute
      em_next.ins    = de.ins;
      em_next.target = de.next + de.off[fsp_pkg::ADDR_W-1:0];
      em_next.alu    = alu;
      em_next.eq     = (a_fw == b_fw);
      em_next.b      = b_fw;

      // memory; a taken branch drops the three younger latches
      mw_next.ins = em.ins;
      mw_next.val = '0;
      unique case (fsp_pkg::opc(em.ins)) inside
        fsp_pkg::OP_LW: begin
          mw_next.val = dm_word;
        end
        fsp_pkg::OP_SW: begin
          dm_we    = 1'b1;
          st_we    = 1'b1;
          dm_waddr = em.alu[fsp_pkg::ADDR_W-1:0];
          dm_wdata = em.b;
        end
        fsp_pkg::OP_BEQ: begin
          if (em.eq) begin
            fd_next.ins = fsp_pkg::NOOP_WORD;
            de_next.ins = fsp_pkg::NOOP_WORD;
            em_next.ins = fsp_pkg::NOOP_WORD;
            pc_next     = em.target;
          end
        end
        fsp_pkg::OP_ADD, fsp_pkg::OP_NOR: begin
          mw_next.val = em.alu;
        end
        default: begin
        end
      endcase

      // writeback
      wbe_next = mw;
      if (fsp_pkg::writes_reg(mw.ins)) begin
        rf_we    = 1'b1;
        rf_waddr = fsp_pkg::dest(mw.ins);
        rf_wdata = mw.val;
      end
    end
  end

  // Read addresses are those of the state after this edge
  assign im_raddr = rst ? '0 : pc_next;
  assign dm_raddr = rst ? '0 : em_next.alu[fsp_pkg::ADDR_W-1:0];
  assign ra       = fsp_pkg::fa(fd_next.ins);
  assign rb       = fsp_pkg::fb(fd_next.ins);

  fsp_ram #(.WIDTH(32), .DEPTH(fsp_pkg::MEM_WORDS)) u_imem (
    .clk   (clk),
    .we    (im_we),
    .waddr (ld_addr),
    .wdata (ld_data),
    .raddr (im_raddr),
    .rdata (im_q)
  );

  fsp_ram #(.WIDTH(32), .DEPTH(fsp_pkg::MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (dm_raddr),
    .rdata (dm_q)
  );

  fsp_ram #(.WIDTH(32), .DEPTH(fsp_pkg::NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (ra),
    .rdata (rfa_q)
  );

  fsp_ram #(.WIDTH(32), .DEPTH(fsp_pkg::NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rb),
    .rdata (rfb_q)
  );

  // Bypass capture for same-edge write/read, register valid bits
  always_ff @(posedge clk) begin
    im_byp  <= ld_data;
    dm_byp  <= dm_wdata;
    rfa_byp <= rf_wdata;
    rfb_byp <= rf_wdata;
    if (rst) begin
      im_hit   <= 1'b0;
      dm_hit   <= 1'b0;
      rfa_hit  <= 1'b0;
      rfb_hit  <= 1'b0;
      rfa_ok   <= 1'b0;
      rfb_ok   <= 1'b0;
      rf_valid <= '0;
    end else begin
      im_hit  <= im_we && (ld_addr == im_raddr);
      dm_hit  <= dm_we && (dm_waddr == dm_raddr);
      rfa_hit <= rf_we && (rf_waddr == ra);
      rfb_hit <= rf_we && (rf_waddr == rb);
      rfa_ok  <= rf_valid[ra];
      rfb_ok  <= rf_valid[rb];
      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
    end
  end

  // Pipeline state: take the _next values on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      cycles <= '0;
      fd     <= '{ins: fsp_pkg::NOOP_WORD, next: '0};
      de     <= '{ins: fsp_pkg::NOOP_WORD, next: '0, a: '0, b: '0, off: '0};
      em     <= '{ins: fsp_pkg::NOOP_WORD, target: '0, eq: 1'b0, alu: '0, b: '0};
      mw     <= '{ins: fsp_pkg::NOOP_WORD, val: '0};
      wbe    <= '{ins: fsp_pkg::NOOP_WORD, val: '0};
    end else if (accept) begin
      pc     <= pc_next;
      cycles <= cycles_next;
      fd     <= fd_next;
      de     <= de_next;
      em     <= em_next;
      mw     <= mw_next;
      wbe    <= wbe_next;
    end
  end

  // Result item
  assign halted_next = (fsp_pkg::opc(mw_next.ins) == fsp_pkg::OP_HALT);
  assign result = {
    6'd0,
    st_we ? dm_wdata : 32'd0,
    st_we ? 10'(dm_waddr) : 10'd0,
    st_we,
    rf_wdata,
    rf_waddr,
    rf_we,
    halted_next,
    cycles_next,
    10'(pc_next)
  };

  // Output register: hold until taken, refill on the same edge it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result;
    end
  end

  // Checks
  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (fsp_pkg::opc(mw.ins) == fsp_pkg::OP_HALT) |=>
    (fsp_pkg::opc(mw.ins) == fsp_pkg::OP_HALT))
    else $error("halt left the memory/writeback latch");

  a_load_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (accept && !act) |=> (pc == $past(pc)) && (cycles == $past(cycles)))
    else $error("load item changed pc or cycle count");

  a_step_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && run) |=> (cycles == $past(cycles) + 32'd1))
    else $error("step did not advance cycle count");

  a_stall_bubble: assert property (@(posedge clk) disable iff (rst)
    (accept && run && stall) |=>
    (fsp_pkg::opc(de.ins) == fsp_pkg::OP_NOOP))
    else $error("load-use hazard did not insert a bubble");

  a_branch_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && run && taken) |=>
    (fsp_pkg::opc(em.ins) == fsp_pkg::OP_NOOP) && (pc == $past(em.target)))
    else $error("taken branch did not flush or redirect");

endmodule
